### rtl/ist_pkg.sv
// Shared types, constants and opcodes for the integer set table.
package ist_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_FIRST  = 3'd3,
        OP_NEXT   = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] item_value;
        logic                    item_valid;
        logic [CNT_W-1:0]        count;
        logic                    status;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic update;
    } t_cmd;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_UPD  = 1'b1
    } t_state;

endpackage

### rtl/ist_ctrl.sv
// Controller state machine: sequences capture and update, owns the output valid flag.
module ist_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output ist_pkg::t_cmd     o_cmd
);

    ist_pkg::t_state r_state;
    ist_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ist_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd.capture = 1'b0;
        o_cmd.update  = 1'b0;
        o_in_stall    = 1'b1;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ist_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ist_pkg::S_UPD;
                end
            end
            ist_pkg::S_UPD: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ist_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ist_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/ist_dpath.sv
// Datapath: entry registers, parallel compare, shift compaction, cursor and result register.
module ist_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ist_pkg::t_cmd      i_cmd,
    input  ist_pkg::t_in_item  i_in_data,
    output ist_pkg::t_out_item o_out_data
);

    localparam int CAP = ist_pkg::CAPACITY;
    localparam int IW  = ist_pkg::IDX_W;
    localparam int CW  = ist_pkg::CNT_W;
    localparam int VW  = ist_pkg::VAL_W;

    logic [VW-1:0]              r_entries [CAP];
    logic [VW-1:0]              n_entries [CAP];
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [CW-1:0]              r_cursor;
    logic [CW-1:0]              n_cursor;
    logic [ist_pkg::OP_W-1:0]   r_op;
    logic [VW-1:0]              r_value;
    logic [CAP-1:0]             r_match;
    logic [CAP-1:0]             n_match;
    ist_pkg::t_out_item         r_out;
    ist_pkg::t_out_item         n_out;
    logic [CAP-1:0]             w_after;
    logic                       w_hit;
    logic [CW-1:0]              w_next_cur;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_match[i] = (r_entries[i] == i_in_data.value) && (CW'(i) < r_count);
        end
    end

    always_comb begin
        logic run;
        run   = 1'b0;
        w_hit = |r_match;
        for (int i = 0; i < CAP; i++) begin
            run        = run | r_match[i];
            w_after[i] = run;
        end
        w_next_cur = (r_cursor < CW'(CAP)) ? r_cursor + 1'b1 : r_cursor;

        n_entries = r_entries;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_out     = '0;
        case (r_op)
            ist_pkg::OP_INSERT: begin
                n_out.hit = w_hit;
                if (!w_hit) begin
                    if (r_count >= CW'(CAP)) begin
                        n_out.status = 1'b1;
                    end else begin
                        n_entries[r_count[IW-1:0]] = r_value;
                        n_count                    = r_count + 1'b1;
                    end
                end
            end
            ist_pkg::OP_REMOVE: begin
                n_out.hit = w_hit;
                if (w_hit) begin
                    for (int i = 0; i < CAP - 1; i++) begin
                        if (w_after[i]) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    n_count = r_count - 1'b1;
                end
            end
            ist_pkg::OP_LOOKUP: begin
                n_out.hit = w_hit;
            end
            ist_pkg::OP_FIRST: begin
                if (r_count != '0) begin
                    n_cursor         = '0;
                    n_out.item_value = r_entries[0];
                    n_out.item_valid = 1'b1;
                end
            end
            ist_pkg::OP_NEXT: begin
                n_cursor = w_next_cur;
                if (w_next_cur < r_count) begin
                    n_out.item_value = r_entries[w_next_cur[IW-1:0]];
                    n_out.item_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n_out.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (i_cmd.update) begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_in_data.opcode;
            r_value <= i_in_data.value;
            r_match <= n_match;
        end
        if (i_cmd.update) begin
            r_entries <= n_entries;
            r_out     <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

### rtl/integer_set_table.sv
// Integer set table: up to CAPACITY distinct 32-bit integers kept in insertion order.
//
// Input channel (i_in_valid, o_in_stall, i_in_data): one item is one operation,
// insert, remove, lookup, iterate first or iterate next. An item is taken at a
// clock edge with valid high and stall low.
// Output channel (o_out_valid, i_out_stall, o_out_data): one result item per
// operation with hit flag, iterated entry, entry count and full status.
// The block takes an item only in its idle state, so a new item waits until the
// last one is applied. The capture step registers the compare of the value
// against all entries at once, the update step applies the insert, the shift-down
// compaction of a remove or the cursor step, and loads the result register.
// When the receiver stalls, the result is held in the output register and the
// next item is still taken and compared; its update waits until the register
// frees, and further items are stalled meanwhile.
// Reset (i_rst_n, synchronous, active low) empties the set, clears the cursor
// and drops any pending result. No clearing pass is needed.
module integer_set_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ist_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ist_pkg::t_out_item o_out_data
);

    ist_pkg::t_cmd w_cmd;

    ist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    ist_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

### rtl/ist_chk.sv
// Port-level checker for the integer set table, bound to the top level.
module ist_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ist_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ist_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> $stable(i_in_data))
        else $error("stalled input item changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item taken while previous one in work");

    a_iter_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.item_valid |->
            !o_out_data.hit && !o_out_data.status)
        else $error("iterate result with hit or status set");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.count <= ist_pkg::CNT_W'(ist_pkg::CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind integer_set_table ist_chk u_ist_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### tb/tb_top.sv
// Self-checking testbench for integer_set_table: queued stimulus, set predictor, result checker.
module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int POOL_SIZE      = 24;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int DRAIN_CYCLES   = 10;
    localparam logic [ist_pkg::OP_W-1:0] OP_LAST_CODE =
        ist_pkg::OP_W'((1 << ist_pkg::OP_W) - 1);

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    ist_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    ist_pkg::t_out_item o_out_data;

    integer_set_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ist_pkg::t_in_item  ops_to_send[$];
    ist_pkg::t_out_item predicted_replies[$];

    logic [ist_pkg::VAL_W-1:0] set_vals [ist_pkg::CAPACITY];
    int set_count = 0;
    int walk_pos  = 0;

    logic [ist_pkg::VAL_W-1:0] value_pool [POOL_SIZE];
    int  send_gap    = 0;
    int  stall_left  = 0;
    bit  calm        = 1'b0;
    int  error_count = 0;
    int  idle_cycles = 0;

    function automatic ist_pkg::t_out_item set_apply_op(ist_pkg::t_in_item it);
        ist_pkg::t_out_item r;
        int pos;
        r = '0;
        pos = set_count;
        for (int k = 0; k < set_count; k++) begin
            if (pos == set_count && set_vals[k] == it.value)
                pos = k;
        end
        case (it.opcode)
            ist_pkg::OP_INSERT: begin
                if (pos < set_count) begin
                    r.hit = 1'b1;
                end else if (set_count >= ist_pkg::CAPACITY) begin
                    r.status = 1'b1;
                end else begin
                    set_vals[set_count] = it.value;
                    set_count++;
                end
            end
            ist_pkg::OP_REMOVE: begin
                if (pos < set_count) begin
                    r.hit = 1'b1;
                    for (int k = pos; k + 1 < set_count; k++)
                        set_vals[k] = set_vals[k+1];
                    set_count--;
                end
            end
            ist_pkg::OP_LOOKUP: begin
                r.hit = (pos < set_count);
            end
            ist_pkg::OP_FIRST: begin
                if (set_count > 0) begin
                    walk_pos     = 0;
                    r.item_value = set_vals[0];
                    r.item_valid = 1'b1;
                end
            end
            ist_pkg::OP_NEXT: begin
                if (walk_pos < ist_pkg::CAPACITY)
                    walk_pos++;
                if (walk_pos < set_count) begin
                    r.item_value = set_vals[walk_pos];
                    r.item_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.count = ist_pkg::CNT_W'(set_count);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [ist_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic add_op(logic [ist_pkg::OP_W-1:0] op, logic [ist_pkg::VAL_W-1:0] v);
        ist_pkg::t_in_item it;
        it.opcode = op;
        it.value  = v;
        ops_to_send = {ops_to_send, it};
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predicted_replies = {predicted_replies, set_apply_op(i_in_data)};
            if (i_in_valid && o_in_stall) begin
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (ops_to_send.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= ops_to_send.pop_front();
                if ($urandom_range(0, 149) == 0)
                    calm = !calm;
                send_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        ist_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_replies.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result item: %p", o_out_data);
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_out_data.hit !== want.hit
                            || o_out_data.item_value !== want.item_value
                            || o_out_data.item_valid !== want.item_valid
                            || o_out_data.count !== want.count
                            || o_out_data.status !== want.status) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: exp hit=%0b val=%h vld=%0b cnt=%0d st=%0b",
                                     want.hit, want.item_value, want.item_valid,
                                     want.count, want.status,
                                     "  got hit=%0b val=%h vld=%0b cnt=%0d st=%0b",
                                     o_out_data.hit, o_out_data.item_value,
                                     o_out_data.item_valid, o_out_data.count,
                                     o_out_data.status);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int made;
        int kind;
        int len;
        int start;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int k = 4; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;

        // directed: empty set, extremes, duplicate, walk past end, removes, undefined codes
        add_op(ist_pkg::OP_NEXT, 32'd5);
        add_op(ist_pkg::OP_FIRST, 32'd0);
        add_op(ist_pkg::OP_LOOKUP, 32'h8000_0000);
        add_op(ist_pkg::OP_REMOVE, 32'd7);
        add_op(ist_pkg::OP_INSERT, 32'h8000_0000);
        add_op(ist_pkg::OP_INSERT, 32'h7fff_ffff);
        add_op(ist_pkg::OP_INSERT, 32'h0000_0000);
        add_op(ist_pkg::OP_INSERT, 32'hffff_ffff);
        add_op(ist_pkg::OP_INSERT, 32'h5555_aaaa);
        add_op(ist_pkg::OP_INSERT, 32'h0000_0000);
        add_op(ist_pkg::OP_LOOKUP, 32'h7fff_ffff);
        add_op(ist_pkg::OP_LOOKUP, 32'h7fff_fffe);
        add_op(ist_pkg::OP_FIRST, 32'hffff_ffff);
        for (int k = 0; k < 5; k++)
            add_op(ist_pkg::OP_NEXT, $urandom);
        add_op(ist_pkg::OP_REMOVE, 32'h0000_0000);
        add_op(ist_pkg::OP_NEXT, 32'h0000_0000);
        add_op(ist_pkg::OP_REMOVE, 32'h8000_0000);
        add_op(ist_pkg::OP_REMOVE, 32'h0000_0000);
        for (int k = ist_pkg::OP_NEXT + 1; k <= OP_LAST_CODE; k++)
            add_op(k[ist_pkg::OP_W-1:0], $urandom);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                len = $urandom_range(5, 25);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5: add_op(ist_pkg::OP_INSERT, pick_value());
                        6, 7, 8, 9:       add_op(ist_pkg::OP_REMOVE, pick_value());
                        10, 11, 12, 13:   add_op(ist_pkg::OP_LOOKUP, pick_value());
                        14, 15:           add_op(ist_pkg::OP_FIRST, $urandom);
                        16, 17, 18:       add_op(ist_pkg::OP_NEXT, $urandom);
                        default: add_op(ist_pkg::OP_W'($urandom_range(ist_pkg::OP_NEXT + 1,
                                                                      OP_LAST_CODE)),
                                        $urandom);
                    endcase
                end
            end else if (kind < 6) begin
                // fill toward and past capacity
                len = $urandom_range(10, POOL_SIZE);
                start = $urandom_range(0, POOL_SIZE - 1);
                for (int k = 0; k < len; k++)
                    add_op(ist_pkg::OP_INSERT, value_pool[(start + k) % POOL_SIZE]);
                add_op(ist_pkg::OP_INSERT, $urandom);
            end else if (kind < 8) begin
                // walk the set, often past the end and into saturation
                len = $urandom_range(1, ist_pkg::CAPACITY + 4);
                add_op(ist_pkg::OP_FIRST, $urandom);
                for (int k = 0; k < len; k++)
                    add_op(ist_pkg::OP_NEXT, $urandom);
            end else begin
                len = $urandom_range(4, POOL_SIZE);
                for (int k = 0; k < len; k++)
                    add_op(ist_pkg::OP_REMOVE, value_pool[$urandom_range(0, POOL_SIZE - 1)]);
            end
            made = made + len + 1;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_to_send.size() > 0 || i_in_valid || predicted_replies.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && predicted_replies.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### integer_set_table.f
rtl/ist_pkg.sv
rtl/ist_ctrl.sv
rtl/ist_dpath.sv
rtl/integer_set_table.sv
rtl/ist_chk.sv
tb/tb_top.sv
